// ===== hw/rtl/lfd_pkg.sv =====
// Shared types, codes and reset values for the line follower drive controller.
package lfd_pkg;

  // Motor direction codes
  localparam logic [1:0] DIR_REV  = 2'd1;
  localparam logic [1:0] DIR_FWD  = 2'd2;
  localparam logic [1:0] DIR_STOP = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RSPIN_FWD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSPIN_REV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUDGE_LEFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NUDGE_RGHT = 3'd5;

  // Reset values of the speed registers
  localparam logic [7:0] RST_STRAIGHT   = 8'd180;
  localparam logic [7:0] RST_LEFT_SPIN  = 8'd180;
  localparam logic [7:0] RST_RSPIN_FWD  = 8'd200;
  localparam logic [7:0] RST_RSPIN_REV  = 8'd170;
  localparam logic [7:0] RST_NUDGE_LEFT = 8'd170;
  localparam logic [7:0] RST_NUDGE_RGHT = 8'd170;

  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_STRAIGHT = 3'd1,
    CMD_LSPIN    = 3'd2,
    CMD_RSPIN    = 3'd3,
    CMD_NLEFT    = 3'd4,
    CMD_NRIGHT   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DISPATCH    = 3'd0,
    PH_NUDGE_LEFT  = 3'd1,
    PH_NUDGE_RIGHT = 3'd2,
    PH_UTURN_FWD   = 3'd3,
    PH_UTURN_SPIN  = 3'd4,
    PH_TURN_SPIN   = 3'd5
  } phase_t;

  typedef struct packed {
    logic sense_far_right;
    logic sense_right;
    logic sense_centre;
    logic sense_left;
    logic sense_far_left;
  } sensors_t;

  typedef struct packed {
    logic [7:0] straight_speed;
    logic [7:0] left_spin_speed;
    logic [7:0] right_spin_forward;
    logic [7:0] right_spin_reverse;
    logic [7:0] nudge_left_speed;
    logic [7:0] nudge_right_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0] dir_b;
    logic [7:0] duty_b;
    logic [1:0] dir_a;
    logic [7:0] duty_a;
  } drive_t;

endpackage

// ===== hw/rtl/lfd_cfg.sv =====
// Speed register file written through the configuration port.
module lfd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output lfd_pkg::cfg_t                  cfg
);
  import lfd_pkg::*;

  // Load the addressed register; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.straight_speed     <= RST_STRAIGHT;
      cfg.left_spin_speed    <= RST_LEFT_SPIN;
      cfg.right_spin_forward <= RST_RSPIN_FWD;
      cfg.right_spin_reverse <= RST_RSPIN_REV;
      cfg.nudge_left_speed   <= RST_NUDGE_LEFT;
      cfg.nudge_right_speed  <= RST_NUDGE_RGHT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STRAIGHT:   cfg.straight_speed     <= cfg_data;
        REG_LEFT_SPIN:  cfg.left_spin_speed    <= cfg_data;
        REG_RSPIN_FWD:  cfg.right_spin_forward <= cfg_data;
        REG_RSPIN_REV:  cfg.right_spin_reverse <= cfg_data;
        REG_NUDGE_LEFT: cfg.nudge_left_speed   <= cfg_data;
        REG_NUDGE_RGHT: cfg.nudge_right_speed  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lfd_ctrl.sv =====
// Drive state machine: latched flags, phase and the command for each sample.
module lfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lfd_pkg::sensors_t sns,
  output lfd_pkg::cmd_t     cmd
);
  import lfd_pkg::*;

  phase_t phase, phase_next;
  logic go_flag, go_flag_next;
  logic ul_flag, ul_flag_next;
  logic ur_flag, ur_flag_next;
  logic tl_flag, tl_flag_next;
  logic tr_flag, tr_flag_next;
  logic pending, pending_next;

  logic fl, l, c, r, fr;
  logic any_uturn, any_turn, fork_seen;

  assign fl = sns.sense_far_left;
  assign l  = sns.sense_left;
  assign c  = sns.sense_centre;
  assign r  = sns.sense_right;
  assign fr = sns.sense_far_right;
  assign any_uturn = ul_flag | ur_flag;
  assign any_turn  = tl_flag | tr_flag;
  assign fork_seen = (fl & l) | (r & fr);

  // Next state of phase and flags
  always_comb begin
    phase_next   = phase;
    go_flag_next = go_flag;
    ul_flag_next = ul_flag;
    ur_flag_next = ur_flag;
    tl_flag_next = tl_flag;
    tr_flag_next = tr_flag;
    pending_next = pending;
    unique case (phase)
      PH_DISPATCH: begin
        if (go_flag) begin
          if (fork_seen) begin
            if (l) begin
              go_flag_next = 1'b0;
              tl_flag_next = 1'b1;
            end else if (r) begin
              go_flag_next = 1'b0;
              tr_flag_next = 1'b1;
            end
          end else begin
            if (fl) begin
              ul_flag_next = 1'b1;
              go_flag_next = 1'b0;
            end else if (fr) begin
              ur_flag_next = 1'b1;
              go_flag_next = 1'b0;
            end
            if (l) begin
              phase_next   = PH_NUDGE_LEFT;
              pending_next = r;
            end else if (r) begin
              phase_next   = PH_NUDGE_RIGHT;
              pending_next = 1'b0;
            end
          end
        end else if (any_uturn) begin
          phase_next = c ? PH_UTURN_FWD : PH_UTURN_SPIN;
        end else if (any_turn) begin
          if (c) begin
            if (tr_flag) tr_flag_next = 1'b0;
            else         tl_flag_next = 1'b0;
            go_flag_next = 1'b1;
          end else begin
            phase_next = PH_TURN_SPIN;
          end
        end
      end
      PH_NUDGE_LEFT, PH_NUDGE_RIGHT: begin
        if (fl) begin
          ul_flag_next = 1'b1;
          go_flag_next = 1'b0;
        end else if (fr) begin
          ur_flag_next = 1'b1;
          go_flag_next = 1'b0;
        end
        if (phase == PH_NUDGE_LEFT) begin
          if (!l) begin
            if (pending) begin
              phase_next   = PH_NUDGE_RIGHT;
              pending_next = 1'b0;
            end else begin
              phase_next = PH_DISPATCH;
            end
          end
        end else if (!r) begin
          phase_next = PH_DISPATCH;
        end
      end
      PH_UTURN_FWD: begin
        if (!any_uturn)  phase_next = PH_DISPATCH;
        else if (!c)     phase_next = PH_UTURN_SPIN;
      end
      PH_UTURN_SPIN: begin
        if (!any_uturn) begin
          phase_next = PH_DISPATCH;
        end else if (c) begin
          if (ul_flag) ul_flag_next = 1'b0;
          else         ur_flag_next = 1'b0;
          go_flag_next = 1'b1;
          phase_next   = PH_DISPATCH;
        end
      end
      PH_TURN_SPIN: begin
        if (!any_turn) begin
          phase_next = PH_DISPATCH;
        end else if (c) begin
          if (tr_flag) tr_flag_next = 1'b0;
          else         tl_flag_next = 1'b0;
          go_flag_next = 1'b1;
          phase_next   = PH_DISPATCH;
        end
      end
      default: phase_next = PH_DISPATCH;
    endcase
  end

  // Command for the current sample
  always_comb begin
    cmd = CMD_STOP;
    unique case (phase)
      PH_DISPATCH: begin
        if (go_flag) begin
          if (fork_seen)  cmd = CMD_STRAIGHT;
          else if (l)     cmd = CMD_NLEFT;
          else if (r)     cmd = CMD_NRIGHT;
          else            cmd = CMD_STRAIGHT;
        end else if (any_uturn) begin
          cmd = c ? CMD_STRAIGHT : (ul_flag ? CMD_LSPIN : CMD_RSPIN);
        end else if (any_turn) begin
          cmd = c ? CMD_STRAIGHT : (tr_flag ? CMD_RSPIN : CMD_LSPIN);
        end
      end
      PH_NUDGE_LEFT: begin
        cmd = (!l && pending) ? CMD_NRIGHT : CMD_NLEFT;
      end
      PH_NUDGE_RIGHT: cmd = CMD_NRIGHT;
      PH_UTURN_FWD: begin
        if (any_uturn) cmd = c ? CMD_STRAIGHT : (ul_flag ? CMD_LSPIN : CMD_RSPIN);
      end
      PH_UTURN_SPIN: begin
        if (any_uturn) cmd = ul_flag ? CMD_LSPIN : CMD_RSPIN;
      end
      PH_TURN_SPIN: begin
        if (any_turn) cmd = tr_flag ? CMD_RSPIN : CMD_LSPIN;
      end
      default: cmd = CMD_STOP;
    endcase
  end

  // Advance the state once per processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DISPATCH;
      go_flag <= 1'b1;
      ul_flag <= 1'b0;
      ur_flag <= 1'b0;
      tl_flag <= 1'b0;
      tr_flag <= 1'b0;
      pending <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      go_flag <= go_flag_next;
      ul_flag <= ul_flag_next;
      ur_flag <= ur_flag_next;
      tl_flag <= tl_flag_next;
      tr_flag <= tr_flag_next;
      pending <= pending_next;
    end
  end

  a_phase_known: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_TURN_SPIN)
    else $error("phase outside the defined range");

  a_turn_phase_flag: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TURN_SPIN) |-> any_turn)
    else $error("turn spin phase without a turn flag");

  a_uturn_phase_flag: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_UTURN_FWD || phase == PH_UTURN_SPIN) |-> any_uturn)
    else $error("U-turn phase without a U-turn flag");

  a_pending_nudge_left: assert property (@(posedge clk) disable iff (rst)
    pending |-> (phase == PH_NUDGE_LEFT))
    else $error("right nudge pending outside a left nudge");

endmodule

// ===== hw/rtl/lfd_emit.sv =====
// Map a drive command onto duty and direction for both motors.
module lfd_emit (
  input  lfd_pkg::cmd_t   cmd,
  input  lfd_pkg::cfg_t   cfg,
  output lfd_pkg::drive_t drive
);
  import lfd_pkg::*;

  logic [7:0] mag_a, mag_b;
  logic       rev_a, rev_b;

  // Select magnitudes and reverse marks
  always_comb begin
    mag_a = '0;
    mag_b = '0;
    rev_a = 1'b0;
    rev_b = 1'b0;
    unique case (cmd)
      CMD_STRAIGHT: begin
        mag_a = cfg.straight_speed;
        mag_b = cfg.straight_speed;
      end
      CMD_LSPIN: begin
        mag_a = cfg.left_spin_speed;
        mag_b = cfg.left_spin_speed;
        rev_a = 1'b1;
      end
      CMD_RSPIN: begin
        mag_a = cfg.right_spin_forward;
        mag_b = cfg.right_spin_reverse;
        rev_b = 1'b1;
      end
      CMD_NLEFT: begin
        mag_a = cfg.nudge_left_speed;
        mag_b = cfg.nudge_left_speed;
        rev_a = 1'b1;
      end
      CMD_NRIGHT: begin
        mag_a = cfg.nudge_right_speed;
        mag_b = cfg.nudge_right_speed;
        rev_b = 1'b1;
      end
      default: ;
    endcase
  end

  // Zero duty always reads as stop
  assign drive.duty_a = mag_a;
  assign drive.duty_b = mag_b;
  assign drive.dir_a  = (mag_a == '0) ? DIR_STOP : (rev_a ? DIR_REV : DIR_FWD);
  assign drive.dir_b  = (mag_b == '0) ? DIR_STOP : (rev_b ? DIR_REV : DIR_FWD);

endmodule

// ===== hw/rtl/line_follower_drive_fsm_top.sv =====
// Top level of the line follower drive controller: stream ports and pipeline registers.
// An accepted sensor transaction is registered at the input, its drive command at m_tdata.
// Throughput: one transaction per cycle unless m_tready stalls; lfd_ctrl steps per sample.
// An input register and an output register separate the two sides, so a sample is
// taken while a finished command still waits on a stalled output.
// Reset (rst, synchronous): pipeline empty, go flag set, phase at dispatch, speeds at defaults.
module line_follower_drive_fsm_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [0] far left, [1] left, [2] centre,
                                                  // [3] right, [4] far right, [7:5] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // [7:0] duty_a, [9:8] dir_a,
                                                  // [17:10] duty_b, [19:18] dir_b, [23:20] zero
  input  logic                          cfg_wr_en,
  input  logic [lfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import lfd_pkg::*;

  logic     in_valid;
  sensors_t in_sns;
  logic     advance;
  cmd_t     cmd;
  cfg_t     cfg;
  drive_t   drive;
  drive_t   out_drive;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sns <= sensors_t'(s_tdata[4:0]);
    end
  end

  lfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .sns  (in_sns),
    .cmd  (cmd)
  );

  lfd_emit u_emit (
    .cmd   (cmd),
    .cfg   (cfg),
    .drive (drive)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive <= drive;
    end
  end

  assign m_tdata = {4'b0000, out_drive};

endmodule

// ===== test/line_follower_drive_fsm_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the line follower drive controller top level.
module line_follower_drive_fsm_top_tb;
  import lfd_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int N_SETTINGS     = 6;
  localparam int RANDOM_ITEMS   = 88;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  // Indexes past the last speed register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [23:0]          m_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = 8'h00;

  line_follower_drive_fsm_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Controller state as the expected behavior tracks it
  cfg_t   speeds;
  logic   go_f, uturn_l_f, uturn_r_f, turn_l_f, turn_r_f, right_pending;
  phase_t ph;

  sensors_t sample_q[$];
  drive_t   drive_q[$];

  int   errors       = 0;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   idle_cycles  = 0;
  int   tx_wait      = 0;
  int   rx_wait      = 0;
  int   rx_gap;
  int   hold_cnt     = 0;
  logic tx_no_idle   = 1'b0;
  logic rx_no_idle   = 1'b0;
  logic squeeze      = 1'b0;
  logic squeezed     = 1'b0;
  drive_t exp_cmd, act_cmd;

  logic [CFG_IDX_W-1:0] speed_regs [6] = '{REG_STRAIGHT, REG_LEFT_SPIN, REG_RSPIN_FWD,
                                           REG_RSPIN_REV, REG_NUDGE_LEFT, REG_NUDGE_RGHT};

  // Opening samples: bit 0 far left .. bit 4 far right
  logic [4:0] opening [25] = '{
    5'b00000, 5'b00100, 5'b11111, 5'b11111, 5'b00000,  // straight, aligned left turn, straight
    5'b00100, 5'b11000, 5'b00000, 5'b00000, 5'b00100,  // right turn spin
    5'b00001, 5'b00100, 5'b00100, 5'b00000, 5'b00100,  // U-turn left, straight then spin
    5'b10000, 5'b00000, 5'b00100, 5'b01010, 5'b00010,  // U-turn right, nudge with right pending
    5'b00000, 5'b01000, 5'b00000, 5'b00010, 5'b10001   // hand over to right nudge, far latch
  };

  // One motor: direction code above the duty magnitude
  function automatic logic [9:0] motor(logic [7:0] mag, logic rev);
    logic [1:0] dir;
    if (mag == 8'd0) dir = DIR_STOP;
    else if (rev) dir = DIR_REV;
    else dir = DIR_FWD;
    return {dir, mag};
  endfunction

  // Map a command to both motors at the current speeds
  function automatic drive_t cmd_drive(cmd_t cmd);
    logic [7:0] mag_a, mag_b;
    logic       rev_a, rev_b;
    mag_a = 8'd0;
    mag_b = 8'd0;
    rev_a = 1'b0;
    rev_b = 1'b0;
    case (cmd)
      CMD_STRAIGHT: begin
        mag_a = speeds.straight_speed;
        mag_b = speeds.straight_speed;
      end
      CMD_LSPIN: begin
        mag_a = speeds.left_spin_speed;
        rev_a = 1'b1;
        mag_b = speeds.left_spin_speed;
      end
      CMD_RSPIN: begin
        mag_a = speeds.right_spin_forward;
        mag_b = speeds.right_spin_reverse;
        rev_b = 1'b1;
      end
      CMD_NLEFT: begin
        mag_a = speeds.nudge_left_speed;
        rev_a = 1'b1;
        mag_b = speeds.nudge_left_speed;
      end
      CMD_NRIGHT: begin
        mag_a = speeds.nudge_right_speed;
        mag_b = speeds.nudge_right_speed;
        rev_b = 1'b1;
      end
      default: ;
    endcase
    return {motor(mag_b, rev_b), motor(mag_a, rev_a)};
  endfunction

  // Far sensors latch a U-turn, left first
  function automatic void latch_uturn(sensors_t s);
    if (s.sense_far_left) begin
      uturn_l_f = 1'b1;
      go_f      = 1'b0;
    end else if (s.sense_far_right) begin
      uturn_r_f = 1'b1;
      go_f      = 1'b0;
    end
  endfunction

  // Advance the tracked state by one sample and return its drive command
  function automatic drive_t predict_drive(sensors_t s);
    cmd_t cmd;
    cmd = CMD_STOP;
    case (ph)
      PH_DISPATCH: begin
        if (go_f) begin
          cmd = CMD_STRAIGHT;
          if ((s.sense_far_left && s.sense_left) || (s.sense_right && s.sense_far_right)) begin
            if (s.sense_left) begin
              go_f     = 1'b0;
              turn_l_f = 1'b1;
            end else if (s.sense_right) begin
              go_f     = 1'b0;
              turn_r_f = 1'b1;
            end
          end else begin
            latch_uturn(s);
            if (s.sense_left) begin
              cmd           = CMD_NLEFT;
              ph            = PH_NUDGE_LEFT;
              right_pending = s.sense_right;
            end else if (s.sense_right) begin
              cmd           = CMD_NRIGHT;
              ph            = PH_NUDGE_RIGHT;
              right_pending = 1'b0;
            end
          end
        end else if (uturn_l_f || uturn_r_f) begin
          if (s.sense_centre) begin
            cmd = CMD_STRAIGHT;
            ph  = PH_UTURN_FWD;
          end else begin
            if (uturn_l_f) cmd = CMD_LSPIN;
            else cmd = CMD_RSPIN;
            ph = PH_UTURN_SPIN;
          end
        end else if (turn_r_f || turn_l_f) begin
          if (s.sense_centre) begin
            // already on the line: finish the turn at once
            if (turn_r_f) turn_r_f = 1'b0;
            else turn_l_f = 1'b0;
            go_f = 1'b1;
            cmd  = CMD_STRAIGHT;
          end else begin
            if (turn_r_f) cmd = CMD_RSPIN;
            else cmd = CMD_LSPIN;
            ph = PH_TURN_SPIN;
          end
        end
      end
      PH_NUDGE_LEFT: begin
        latch_uturn(s);
        if (s.sense_left) begin
          cmd = CMD_NLEFT;
        end else if (right_pending) begin
          cmd           = CMD_NRIGHT;
          ph            = PH_NUDGE_RIGHT;
          right_pending = 1'b0;
        end else begin
          cmd = CMD_NLEFT;
          ph  = PH_DISPATCH;
        end
      end
      PH_NUDGE_RIGHT: begin
        latch_uturn(s);
        cmd = CMD_NRIGHT;
        if (!s.sense_right) ph = PH_DISPATCH;
      end
      PH_UTURN_FWD: begin
        if (!(uturn_l_f || uturn_r_f)) begin
          ph = PH_DISPATCH;
        end else if (s.sense_centre) begin
          cmd = CMD_STRAIGHT;
        end else begin
          if (uturn_l_f) cmd = CMD_LSPIN;
          else cmd = CMD_RSPIN;
          ph = PH_UTURN_SPIN;
        end
      end
      PH_UTURN_SPIN: begin
        if (!(uturn_l_f || uturn_r_f)) begin
          ph = PH_DISPATCH;
        end else begin
          if (uturn_l_f) cmd = CMD_LSPIN;
          else cmd = CMD_RSPIN;
          if (s.sense_centre) begin
            if (uturn_l_f) uturn_l_f = 1'b0;
            else uturn_r_f = 1'b0;
            go_f = 1'b1;
            ph   = PH_DISPATCH;
          end
        end
      end
      PH_TURN_SPIN: begin
        if (!(turn_r_f || turn_l_f)) begin
          ph = PH_DISPATCH;
        end else begin
          if (turn_r_f) cmd = CMD_RSPIN;
          else cmd = CMD_LSPIN;
          if (s.sense_centre) begin
            if (turn_r_f) turn_r_f = 1'b0;
            else turn_l_f = 1'b0;
            go_f = 1'b1;
            ph   = PH_DISPATCH;
          end
        end
      end
      default: ph = PH_DISPATCH;
    endcase
    return cmd_drive(cmd);
  endfunction

  function automatic int draw_gap(logic no_idle);
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic sensors_t rand_sample();
    return sensors_t'(5'($urandom));
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Sender: offer queued samples, hold until taken, then idle for the drawn gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      tx_wait  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_q.push_back(predict_drive(sensors_t'(s_tdata[4:0])));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0) begin
          tx_wait  <= tx_wait - 1;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_tdata  <= {3'b000, sample_q.pop_front()};
          s_tvalid <= 1'b1;
          tx_wait  <= draw_gap(tx_no_idle);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction against the oldest expected command
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
      hold_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (drive_q.size() == 0) begin
          $display("%0t ns: drive command %h with none expected", $time, m_tdata);
          errors++;
        end else begin
          exp_cmd = drive_q.pop_front();
          act_cmd = drive_t'(m_tdata[19:0]);
          check_field("duty_a", exp_cmd.duty_a, act_cmd.duty_a);
          check_field("dir_a", exp_cmd.dir_a, act_cmd.dir_a);
          check_field("duty_b", exp_cmd.duty_b, act_cmd.duty_b);
          check_field("dir_b", exp_cmd.dir_b, act_cmd.dir_b);
          check_field("pad", 0, m_tdata[23:20]);
        end
      end
      // Long hold-off so the pipeline fills and back-pressures the input
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= (hold_cnt == 1);
      end else if (squeeze && !squeezed) begin
        squeezed <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        rx_gap = draw_gap(rx_no_idle);
        rx_wait  <= rx_gap;
        m_tready <= (rx_gap == 0);
      end else if (rx_wait != 0) begin
        rx_wait  <= rx_wait - 1;
        m_tready <= (rx_wait == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("line_follower_drive_fsm_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Write one register and track it; caller drops the enable after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_STRAIGHT:   speeds.straight_speed     = val;
      REG_LEFT_SPIN:  speeds.left_spin_speed    = val;
      REG_RSPIN_FWD:  speeds.right_spin_forward = val;
      REG_RSPIN_REV:  speeds.right_spin_reverse = val;
      REG_NUDGE_LEFT: speeds.nudge_left_speed   = val;
      REG_NUDGE_RGHT: speeds.nudge_right_speed  = val;
      default: ;
    endcase
  endtask

  // Wait until every sample is taken and every command has come back
  task automatic wait_drained();
    @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_centre(int n, logic on_line);
    sensors_t s;
    repeat (n) begin
      s = rand_sample();
      s.sense_centre = on_line;
      sample_q.push_back(s);
    end
  endtask

  // Queue one maneuver-shaped sequence with random content, or a burst of noise
  task automatic push_maneuver();
    sensors_t s;
    int       n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat (n) begin
          s = '0;
          s.sense_centre = 1'b1;
          if ($urandom_range(0, 3) == 0) s = rand_sample();
          sample_q.push_back(s);
        end
      end
      2: begin
        repeat (n) begin
          s = rand_sample();
          s.sense_left      = 1'b1;
          s.sense_far_left  = 1'b0;
          s.sense_far_right = 1'b0;
          sample_q.push_back(s);
        end
        s = rand_sample();
        s.sense_left = 1'b0;
        sample_q.push_back(s);
      end
      3: begin
        repeat (n) begin
          s = rand_sample();
          s.sense_right     = 1'b1;
          s.sense_left      = 1'b0;
          s.sense_far_left  = 1'b0;
          s.sense_far_right = 1'b0;
          sample_q.push_back(s);
        end
        s = rand_sample();
        s.sense_right = 1'b0;
        sample_q.push_back(s);
      end
      4: begin
        s = rand_sample();
        s.sense_far_left = 1'b1;
        s.sense_left     = 1'b1;
        sample_q.push_back(s);
        push_centre(n, 1'b0);
        push_centre(1, 1'b1);
      end
      5: begin
        s = rand_sample();
        s.sense_right     = 1'b1;
        s.sense_far_right = 1'b1;
        s.sense_left      = 1'b0;
        sample_q.push_back(s);
        push_centre(n, 1'b0);
        push_centre(1, 1'b1);
      end
      6: begin
        s = rand_sample();
        s.sense_far_left  = 1'b1;
        s.sense_left      = 1'b0;
        s.sense_far_right = 1'b0;
        sample_q.push_back(s);
        push_centre($urandom_range(0, 3), 1'b1);
        push_centre(n, 1'b0);
        push_centre(1, 1'b1);
      end
      7: begin
        s = rand_sample();
        s.sense_far_right = 1'b1;
        s.sense_right     = 1'b0;
        s.sense_far_left  = 1'b0;
        sample_q.push_back(s);
        push_centre($urandom_range(0, 3), 1'b1);
        push_centre(n, 1'b0);
        push_centre(1, 1'b1);
      end
      default: begin
        repeat (n) sample_q.push_back(rand_sample());
      end
    endcase
  endtask

  // Load one speed setting: 1 all max, 2 all zero, 4 mixed extremes, else random; 3 also writes both spare indexes
  task automatic apply_setting(int k);
    logic [7:0] val;
    if (k == 3) cfg_write(REG_SPARE_LO, 8'($urandom));
    foreach (speed_regs[i]) begin
      case (k)
        1:       val = 8'hFF;
        2:       val = 8'h00;
        4:       val = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        default: val = 8'($urandom);
      endcase
      cfg_write(speed_regs[i], val);
    end
    if (k == 3) cfg_write(REG_SPARE_HI, 8'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Main sequence: reset, then one stimulus phase per speed setting
  initial begin
    int target;
    speeds        = {RST_STRAIGHT, RST_LEFT_SPIN, RST_RSPIN_FWD,
                     RST_RSPIN_REV, RST_NUDGE_LEFT, RST_NUDGE_RGHT};
    go_f          = 1'b1;
    uturn_l_f     = 1'b0;
    uturn_r_f     = 1'b0;
    turn_l_f      = 1'b0;
    turn_r_f      = 1'b0;
    right_pending = 1'b0;
    ph            = PH_DISPATCH;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k != 0) begin
        wait_drained();
        apply_setting(k);
      end
      tx_no_idle = (k == 1 || k == N_SETTINGS - 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
      rx_no_idle = (k == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
      squeeze    = (k == N_SETTINGS - 1);
      if (k == 0) begin
        foreach (opening[i]) sample_q.push_back(sensors_t'(opening[i]));
      end
      target = sample_q.size() + RANDOM_ITEMS;
      while (sample_q.size() < target) push_maneuver();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sensor samples across %0d speed settings; %0d drive commands checked.",
             items_sent, N_SETTINGS, results_seen);
    $display("Speeds ran from all zero to all max, with one %0d-cycle output stall.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("line_follower_drive_fsm_top: match");
    end else begin
      $display("line_follower_drive_fsm_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lfd_pkg.sv
hw/rtl/lfd_cfg.sv
hw/rtl/lfd_ctrl.sv
hw/rtl/lfd_emit.sv
hw/rtl/line_follower_drive_fsm_top.sv
test/line_follower_drive_fsm_top_tb.sv
